/* src/aabb_pkg.sv */
// Shared types, codes and bound arithmetic for the box overlap table.
`default_nettype none
package aabb_pkg;

  localparam int AXES    = 3;
  localparam int BND_W   = 17;
  localparam int CTR_W   = 24;
  localparam int EXT_W   = 23;
  localparam int OSLOT_W = 5;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_IN_USE = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef logic signed [BND_W-1:0] bnd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [OSLOT_W-1:0]        slot;
    logic signed [CTR_W-1:0]   center_x;
    logic signed [CTR_W-1:0]   center_y;
    logic signed [CTR_W-1:0]   center_z;
    logic [EXT_W-1:0]          extent_x;
    logic [EXT_W-1:0]          extent_y;
    logic [EXT_W-1:0]          extent_z;
  } in_req_t;

  typedef struct packed {
    logic [OSLOT_W-1:0] hit_slot;
    logic               hit_valid;
    status_t            status;
    logic               last;
  } out_res_t;

  typedef struct packed {
    bnd_t [AXES-1:0] lo;
    bnd_t [AXES-1:0] hi;
  } bnd_row_t;

  typedef struct packed {
    logic load;
    logic bounds;
    logic exec;
    logic scan;
    logic flush;
  } dp_ctl_t;

  typedef struct packed {
    logic is_search;
    logic room;
    logic scan_done;
  } dp_sts_t;

  // floor((2c - e) / 512)
  function automatic bnd_t lower_of(logic signed [CTR_W-1:0] c, logic [EXT_W-1:0] e);
    logic signed [CTR_W+1:0] c2;
    logic signed [CTR_W+1:0] ev;
    logic signed [CTR_W+1:0] v;
    c2 = {c[CTR_W-1], c, 1'b0};
    ev = {3'b000, e};
    v  = c2 - ev;
    return v[CTR_W+1:9];
  endfunction

  // ceil((2c + e) / 512)
  function automatic bnd_t upper_of(logic signed [CTR_W-1:0] c, logic [EXT_W-1:0] e);
    logic signed [CTR_W+1:0] c2;
    logic signed [CTR_W+1:0] ev;
    logic signed [CTR_W+1:0] v;
    c2 = {c[CTR_W-1], c, 1'b0};
    ev = {3'b000, e};
    v  = c2 + ev + 26'sd511;
    return v[CTR_W+1:9];
  endfunction

endpackage
`default_nettype wire

/* src/aabb_overlap_query_table.sv */
// Top level of the axis-aligned box overlap table.
// Holds one box per slot as integer bounds per axis in a SLOTS-row memory (six 17-bit
// bounds per row) with a flip-flop in-use bit per slot, cleared at reset. Create,
// update and remove pass the idle, bounds and exec states to the result register;
// a search reads one memory row and makes one overlap compare per cycle while the
// result register has room, and halts while a result waits on out_stall. One request
// is in work at a time; the next is taken while the last result still waits. Hits
// come in ascending slot order, last marks the final one. axis_count selects two or
// three axes. The user must write it only while the block is idle; it is not checked.
`default_nettype none
module aabb_overlap_query_table
  import aabb_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_req_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_res_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  aabb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  aabb_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule
`default_nettype wire

/* src/aabb_ctrl.sv */
// Command sequencer for the box overlap table.
`default_nettype none
module aabb_ctrl
  import aabb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_ctl_t      ctl
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BOUNDS = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_FLUSH  = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_BOUNDS;
        end
      end
      S_BOUNDS: begin
        ctl.bounds = 1'b1;
        state_nxt  = sts.is_search ? S_SCAN : S_EXEC;
      end
      S_EXEC: begin
        if (sts.room) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.room) begin
          ctl.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SPARE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/aabb_dp.sv */
// Datapath of the box overlap table: bounds, slot table, scan and result register.
`default_nettype none
module aabb_dp
  import aabb_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_req_t  in_data,
  input  wire logic     cfg_valid,
  input  wire logic [1:0] cfg_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_data,
  input  wire dp_ctl_t  ctl,
  output dp_sts_t       sts
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int IDX_W  = (SLOT_W > OSLOT_W) ? SLOT_W : OSLOT_W;

  in_req_t           req_r;
  bnd_t [AXES-1:0]   qlo_r, qhi_r;
  logic [1:0]        axis_cnt_r;
  logic [SLOTS-1:0]  in_use_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic              cmp_valid_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  bnd_row_t          rd_row_r;
  logic              pend_valid_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic              out_valid_r;
  out_res_t          out_r;

  bnd_row_t          mem [SLOTS];

  logic              out_fire;
  logic              room;
  logic              scan_adv;
  logic              rd_more;
  logic              rd_en;
  logic              hit;
  logic [AXES-1:0]   axis_ok;
  logic [IDX_W-1:0]  slot_ext;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_ok;
  logic              slot_used;
  status_t           exec_status;
  logic              wr_en;
  logic              clr_en;
  bnd_row_t          wr_row;
  logic              load_out;
  out_res_t          load_val;
  logic [IDX_W-1:0]  pend_ext;

  assign out_fire = out_valid_r && !out_stall;
  assign room     = !out_valid_r || out_fire;
  assign scan_adv = ctl.scan && room;
  assign rd_more  = scan_idx_r < CNT_W'(SLOTS);
  assign rd_en    = scan_adv && rd_more;

  assign sts.is_search = (req_r.cmd == CMD_SEARCH);
  assign sts.room      = room;
  assign sts.scan_done = !rd_more && !cmp_valid_r;

  assign slot_ext  = IDX_W'(req_r.slot);
  assign slot_idx  = slot_ext[SLOT_W-1:0];
  assign slot_ok   = {1'b0, slot_ext} < (IDX_W+1)'(SLOTS);
  assign slot_used = in_use_r[slot_idx];
  assign pend_ext  = IDX_W'(pend_slot_r);

  always_comb begin
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    exec_status = ST_OK;
    if (!slot_ok) begin
      exec_status = ST_EMPTY;
    end else if (req_r.cmd == CMD_CREATE && slot_used) begin
      exec_status = ST_IN_USE;
    end else if (req_r.cmd != CMD_CREATE && !slot_used) begin
      exec_status = ST_EMPTY;
    end else if (req_r.cmd == CMD_REMOVE) begin
      clr_en = ctl.exec;
    end else begin
      wr_en = ctl.exec;
    end
  end

  assign wr_row.lo = qlo_r;
  assign wr_row.hi = qhi_r;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      axis_ok[a] = !(($signed(rd_row_r.lo[a]) > $signed(qhi_r[a])) ||
                     ($signed(rd_row_r.hi[a]) < $signed(qlo_r[a])));
    end
    hit = cmp_valid_r && in_use_r[cmp_idx_r] && axis_ok[0] && axis_ok[1] &&
          (axis_ok[2] || axis_cnt_r != 2'd3);
  end

  always_comb begin
    load_out = 1'b0;
    load_val = '0;
    if (ctl.exec) begin
      load_out        = 1'b1;
      load_val.status = exec_status;
      load_val.last   = 1'b1;
    end else if (ctl.flush) begin
      load_out           = 1'b1;
      load_val.last      = 1'b1;
      load_val.hit_valid = pend_valid_r;
      load_val.hit_slot  = pend_valid_r ? pend_ext[OSLOT_W-1:0] : '0;
    end else if (scan_adv && hit && pend_valid_r) begin
      load_out           = 1'b1;
      load_val.hit_valid = 1'b1;
      load_val.hit_slot  = pend_ext[OSLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_data;
    end
    if (ctl.bounds) begin
      qlo_r[0] <= lower_of(req_r.center_x, req_r.extent_x);
      qhi_r[0] <= upper_of(req_r.center_x, req_r.extent_x);
      qlo_r[1] <= lower_of(req_r.center_y, req_r.extent_y);
      qhi_r[1] <= upper_of(req_r.center_y, req_r.extent_y);
      qlo_r[2] <= lower_of(req_r.center_z, req_r.extent_z);
      qhi_r[2] <= upper_of(req_r.center_z, req_r.extent_z);
    end
    if (rd_en) begin
      cmp_idx_r <= scan_idx_r[SLOT_W-1:0];
    end
    if (scan_adv && hit) begin
      pend_slot_r <= cmp_idx_r;
    end
    if (load_out) begin
      out_r <= load_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_idx] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[scan_idx_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_cnt_r   <= 2'd2;
      in_use_r     <= '0;
      scan_idx_r   <= '0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        axis_cnt_r <= cfg_data;
      end
      if (wr_en) begin
        in_use_r[slot_idx] <= 1'b1;
      end else if (clr_en) begin
        in_use_r[slot_idx] <= 1'b0;
      end
      if (ctl.bounds) begin
        scan_idx_r   <= '0;
        cmp_valid_r  <= 1'b0;
        pend_valid_r <= 1'b0;
      end else if (scan_adv) begin
        cmp_valid_r <= rd_more;
        if (rd_more) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (hit) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_use_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !ctl.exec) |=> (in_use_r == $past(in_use_r)))
    else $error("slot table changed outside a command");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= CNT_W'(SLOTS))
    else $error("scan index beyond table");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.hit_valid) |-> (out_r.status == ST_OK))
    else $error("hit carries error status");

  a_not_last_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> out_r.hit_valid)
    else $error("non-final result without hit");
`endif

endmodule
`default_nettype wire

/* test/aabb_overlap_query_table_tb.sv */
// Self-checking bench for the box overlap table: directed and random commands, shadow table.
`default_nettype none
module aabb_overlap_query_table_tb;
  import aabb_pkg::*;

  localparam int SLOTS          = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 60;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_req_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_res_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data  = 2'd0;

  in_req_t    queued_commands [$];
  out_res_t   pending_reports [$];

  logic [1:0] shadow_axis_count = 2'd2;
  bit         shadow_used [SLOTS];
  int         shadow_lo [AXES][SLOTS];
  int         shadow_hi [AXES][SLOTS];

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         quiet          = 1'b0;
  int         send_gap       = 0;
  int         stall_left     = 0;
  int         idle_cycles    = 0;
  int         failures       = 0;
  out_res_t   want;

  logic [1:0] axis_plan  [RANDOM_PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
  int         send_plan  [RANDOM_PHASES] = '{30, 0, 50, 10, 0};
  int         stall_plan [RANDOM_PHASES] = '{30, 0, 10, 50, 0};

  aabb_overlap_query_table #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void box_bounds(in_req_t r, int axis, output int lo, output int hi);
    int c;
    int e;
    case (axis)
      0: begin
        c = r.center_x;
        e = r.extent_x;
      end
      1: begin
        c = r.center_y;
        e = r.extent_y;
      end
      default: begin
        c = r.center_z;
        e = r.extent_z;
      end
    endcase
    lo = (2 * c - e) >>> 9;
    hi = (2 * c + e + 511) >>> 9;
  endfunction

  function automatic void run_command(in_req_t r);
    out_res_t           res;
    int                 qlo [AXES];
    int                 qhi [AXES];
    logic [OSLOT_W-1:0] hits [$];
    int                 axes;
    int                 lo;
    int                 hi;
    bit                 hit;
    res           = '0;
    res.status    = ST_OK;
    res.last      = 1'b1;
    if (r.cmd == CMD_SEARCH) begin
      axes = (shadow_axis_count == 2'd3) ? 3 : 2;
      for (int a = 0; a < AXES; a++) box_bounds(r, a, qlo[a], qhi[a]);
      for (int s = 0; s < SLOTS; s++) begin
        hit = shadow_used[s];
        for (int a = 0; a < axes; a++) begin
          if (shadow_lo[a][s] > qhi[a] || shadow_hi[a][s] < qlo[a]) hit = 1'b0;
        end
        if (hit) hits.push_back(s[OSLOT_W-1:0]);
      end
      if (hits.size() == 0) begin
        pending_reports.push_back(res);
      end else begin
        foreach (hits[i]) begin
          res.hit_slot  = hits[i];
          res.hit_valid = 1'b1;
          res.last      = (i == hits.size() - 1);
          pending_reports.push_back(res);
        end
      end
    end else begin
      if (int'(r.slot) >= SLOTS) begin
        res.status = ST_EMPTY;
      end else if (r.cmd == CMD_CREATE && shadow_used[r.slot]) begin
        res.status = ST_IN_USE;
      end else if (r.cmd != CMD_CREATE && !shadow_used[r.slot]) begin
        res.status = ST_EMPTY;
      end else if (r.cmd == CMD_REMOVE) begin
        shadow_used[r.slot] = 1'b0;
      end else begin
        for (int a = 0; a < AXES; a++) begin
          box_bounds(r, a, lo, hi);
          shadow_lo[a][r.slot] = lo;
          shadow_hi[a][r.slot] = hi;
        end
        shadow_used[r.slot] = 1'b1;
      end
      pending_reports.push_back(res);
    end
  endfunction

  function automatic in_req_t box(cmd_t c, int s, int cx, int cy, int cz,
                                  int ex, int ey, int ez);
    in_req_t r;
    r.cmd      = c;
    r.slot     = s[OSLOT_W-1:0];
    r.center_x = cx[CTR_W-1:0];
    r.center_y = cy[CTR_W-1:0];
    r.center_z = cz[CTR_W-1:0];
    r.extent_x = ex[EXT_W-1:0];
    r.extent_y = ey[EXT_W-1:0];
    r.extent_z = ez[EXT_W-1:0];
    return r;
  endfunction

  function automatic int random_center(bit wide);
    int v;
    if (wide) begin
      v = $urandom();
    end else begin
      v = $urandom_range(0, 32768);
      v = v - 16384;
    end
    return v;
  endfunction

  function automatic int random_extent(bit wide);
    int v;
    if (wide) v = $urandom();
    else v = $urandom_range(0, 8192);
    return v;
  endfunction

  function automatic in_req_t random_command();
    int   pick;
    bit   wide;
    cmd_t c;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 9) == 0);
    if (pick < 30) c = CMD_CREATE;
    else if (pick < 45) c = CMD_UPDATE;
    else if (pick < 58) c = CMD_REMOVE;
    else c = CMD_SEARCH;
    return box(c, $urandom_range(0, 31),
               random_center(wide), random_center(wide), random_center(wide),
               random_extent(wide), random_extent(wide), random_extent(wide));
  endfunction

  task automatic wait_settled();
    while (!(queued_commands.size() == 0 && !in_valid && pending_reports.size() == 0))
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_axis_count(logic [1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_axis_count = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) run_command(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          in_data  <= queued_commands.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unrequested result: hit_slot %0d hit_valid %0d status %0d last %0d",
                 out_data.hit_slot, out_data.hit_valid, out_data.status, out_data.last);
          failures++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.hit_slot !== want.hit_slot) begin
            $error("hit_slot: expected %0d, actual %0d", want.hit_slot, out_data.hit_slot);
            failures++;
          end
          if (out_data.hit_valid !== want.hit_valid) begin
            $error("hit_valid: expected %0d, actual %0d", want.hit_valid, out_data.hit_valid);
            failures++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            failures++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            failures++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
        stall_left <= $urandom_range(0, 10);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    @(negedge clk);
    queued_commands.push_back(box(CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_UPDATE, 3, 0, 0, 0, 256, 256, 256));
    queued_commands.push_back(box(CMD_REMOVE, 31, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_CREATE, 0, -8388608, 8388607, 0,
                                  8388607, 8388607, 8388607));
    queued_commands.push_back(box(CMD_CREATE, 0, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_CREATE, 31, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_CREATE, 7, 8388607, -8388608, 25600, 0, 0, 0));
    queued_commands.push_back(box(CMD_CREATE, 12, 2561, -1283, 0, 513, 1, 300));
    queued_commands.push_back(box(CMD_CREATE, 20, 8388607, 8388607, 8388607,
                                  8388607, 8388607, 8388607));
    queued_commands.push_back(box(CMD_UPDATE, 7, 0, 0, 25600, 512, 512, 512));
    queued_commands.push_back(box(CMD_SEARCH, 9, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, 256, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, 0, 0, 0, 8388607, 8388607, 8388607));
    queued_commands.push_back(box(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_UPDATE, 12, -3000001, -2999999, -8388608, 1023, 1, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, -3000000, -3000000, 0, 2048, 2048, 0));
    wait_settled();
    write_axis_count(2'd3);
    @(negedge clk);
    queued_commands.push_back(box(CMD_SEARCH, 0, 0, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, 256, 0, 0, 0, 0, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, 0, 0, 25600, 0, 0, 0));
    queued_commands.push_back(box(CMD_SEARCH, 0, 0, 0, 0, 8388607, 8388607, 8388607));
    queued_commands.push_back(box(CMD_SEARCH, 0, -8388608, -8388608, -8388608,
                                  8388607, 8388607, 8388607));
    wait_settled();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_axis_count(axis_plan[p]);
      @(negedge clk);
      send_idle_pct  = send_plan[p];
      recv_stall_pct = stall_plan[p];
      quiet          = (p == RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) queued_commands.push_back(random_command());
      wait_settled();
    end
    repeat (40) @(negedge clk);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

/* aabb_overlap_query_table.f */
src/aabb_pkg.sv
src/aabb_ctrl.sv
src/aabb_dp.sv
src/aabb_overlap_query_table.sv
test/aabb_overlap_query_table_tb.sv
